// ----- rtl/core/btt_pkg.sv -----
package btt_pkg;

  localparam int NUM_BUCKETS = 4096;
  localparam int WAYS        = 5;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [1:0] BND_EXACT   = 2'd3;
  localparam logic       KIND_PROBE  = 1'b0;
  localparam logic       KIND_STORE  = 1'b1;

  typedef struct packed {
    logic [63:0] data;
    logic [31:0] check;
  } btt_entry_t;

  typedef btt_entry_t [WAYS-1:0] btt_row_t;

  typedef struct packed {
    logic              kind;
    logic [BKT_W-1:0]  bucket;
    logic [31:0]       key32;
    logic [15:0]       score;
    logic [15:0]       static_eval;
    logic              pv_flag;
    logic [1:0]        bound_kind;
    logic [9:0]        best_move_code;
    logic              move_given;
    logic [7:0]        search_depth;
  } btt_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] score;
    logic [15:0] eval;
    logic        pv;
    logic [1:0]  bound;
    logic [9:0]  move_code;
    logic [7:0]  depth;
    logic        written;
  } btt_res_t;

  typedef struct packed {
    logic     wr_en;
    btt_row_t row;
    btt_res_t res;
  } btt_upd_t;

endpackage

// ----- rtl/core/btt_select.sv -----
module btt_select import btt_pkg::*; (
  input  btt_row_t  row,
  input  btt_item_t item,
  input  logic [7:0] age,
  output btt_upd_t  upd
);

  logic [31:0]       key_w   [WAYS];
  logic [WAYS-1:0]   match;
  logic signed [8:0] rscore  [WAYS];
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  min_way;
  logic signed [8:0] min_score;
  logic [WAY_W-1:0]  rep_way;
  btt_entry_t        sel;
  btt_entry_t        new_ent;
  logic [31:0]       sel_d1;
  logic [31:0]       new_d0;
  logic [31:0]       new_d1;
  logic [31:0]       ref_d1;
  logic [9:0]        code;
  logic              skip;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      key_w[w]  = row[w].check ^ row[w].data[31:0] ^ row[w].data[63:32];
      match[w]  = (key_w[w] == item.key32);
      rscore[w] = $signed({1'b0, row[w].data[55:48]})
                - $signed({1'b0, 8'(age - row[w].data[63:56])});
    end
  end

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    min_way   = '0;
    min_score = rscore[0];
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    // earliest way wins a tie
    for (int w = 1; w < WAYS; w++) begin
      if (rscore[w] < min_score) begin
        min_way   = WAY_W'(w);
        min_score = rscore[w];
      end
    end
    rep_way = hit ? hit_way : min_way;
  end

  always_comb begin
    sel    = row[rep_way];
    sel_d1 = sel.data[63:32];
    ref_d1 = {age, sel_d1[23:0]};
    skip   = hit && (item.bound_kind != BND_EXACT)
           && ({1'b0, item.search_depth} + 9'd2 < {1'b0, sel_d1[23:16]});
    code   = (hit && !item.move_given) ? sel_d1[9:0] : item.best_move_code;
    new_d0 = {item.static_eval, item.score};
    new_d1 = {age, item.search_depth, item.pv_flag, item.bound_kind, 3'b000, code};

    new_ent = sel;
    upd     = '0;
    upd.row = row;

    if (item.kind == KIND_STORE) begin
      new_ent.data  = {new_d1, new_d0};
      new_ent.check = item.key32 ^ new_d0 ^ new_d1;
      upd.wr_en       = !skip;
      upd.res.written = !skip;
    end else begin
      // refresh age, keep the key unchanged
      new_ent.data  = {ref_d1, sel.data[31:0]};
      new_ent.check = sel.check ^ sel_d1 ^ ref_d1;
      upd.wr_en         = hit;
      upd.res.found     = hit;
      upd.res.score     = hit ? sel.data[15:0]  : 16'd0;
      upd.res.eval      = hit ? sel.data[31:16] : 16'd0;
      upd.res.pv        = hit & sel_d1[15];
      upd.res.bound     = hit ? sel_d1[14:13]   : 2'd0;
      upd.res.move_code = hit ? sel_d1[9:0]     : 10'd0;
      upd.res.depth     = hit ? sel_d1[23:16]   : 8'd0;
    end
    upd.row[rep_way] = new_ent;
  end

endmodule

// ----- rtl/core/bucketed_transposition_table.sv -----
// Channel | Beat                                   | Handshake
// in      | kind, key, score, eval, pv, bound,     | in_valid / in_ready
//         | move code, move given, depth           |
// out     | found, fields of hit entry, written    | out_valid / out_ready
// cfg     | current age (8 bits)                   | cfg_valid / cfg_ready
//
// Each beat reads one bucket row from the single-port-write memory, then
// compares, chooses and writes back the whole row.
// After reset a clearing pass zeroes the 4096 rows, one a cycle; no input
// beat is taken until the pass ends. Configuration writes are always taken.
// A result waiting on out_ready holds the write back; the next input beat is
// taken only once the previous beat has finished its write-back step.
module bucketed_transposition_table import btt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [63:0]        in_position_key,
  input  logic signed [15:0] in_score,
  input  logic signed [15:0] in_static_eval,
  input  logic               in_pv_flag,
  input  logic [1:0]         in_bound_kind,
  input  logic [9:0]         in_best_move_code,
  input  logic               in_move_given,
  input  logic [7:0]         in_search_depth,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic signed [15:0] out_score,
  output logic signed [15:0] out_eval,
  output logic               out_pv,
  output logic [1:0]         out_bound,
  output logic [9:0]         out_move_code,
  output logic [7:0]         out_depth,
  output logic               out_written,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t           state_r;
  logic [BKT_W-1:0] clr_addr_r;
  logic [7:0]       age_r;
  logic             out_valid_r;
  btt_res_t         res_r;
  btt_item_t        item_r;
  btt_row_t         rd_row_r;
  btt_row_t         mem [NUM_BUCKETS];
  btt_upd_t         upd;
  logic             in_acc;
  logic             slot_free;
  logic             commit;
  logic             wr_en;
  logic [BKT_W-1:0] wr_addr;
  btt_row_t         wr_row;
  logic [BKT_W-1:0] rd_addr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign commit    = (state_r == S_LOOK) && slot_free;

  // NUM_BUCKETS is a power of two: the bucket index is the top BKT_W key bits
  assign rd_addr = in_position_key[63 -: BKT_W];

  assign wr_en   = (state_r == S_CLEAR) || (commit && upd.wr_en);
  assign wr_addr = (state_r == S_CLEAR) ? clr_addr_r : item_r.bucket;
  assign wr_row  = (state_r == S_CLEAR) ? '0 : upd.row;

  btt_select u_select (
    .row  (rd_row_r),
    .item (item_r),
    .age  (age_r),
    .upd  (upd)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (in_acc) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.kind           <= in_kind;
      item_r.bucket         <= rd_addr;
      item_r.key32          <= in_position_key[31:0];
      item_r.score          <= in_score;
      item_r.static_eval    <= in_static_eval;
      item_r.pv_flag        <= in_pv_flag;
      item_r.bound_kind     <= in_bound_kind;
      item_r.best_move_code <= in_best_move_code;
      item_r.move_given     <= in_move_given;
      item_r.search_depth   <= in_search_depth;
    end
    if (commit) begin
      res_r <= upd.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      age_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        age_r <= cfg_data;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + BKT_W'(1);
          if (clr_addr_r == BKT_W'(NUM_BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          // hold until the output register can take the result
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = res_r.found;
  assign out_score     = res_r.score;
  assign out_eval      = res_r.eval;
  assign out_pv        = res_r.pv;
  assign out_bound     = res_r.bound;
  assign out_move_code = res_r.move_code;
  assign out_depth     = res_r.depth;
  assign out_written   = res_r.written;

endmodule
